// File: rtl/tuea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tuea_pkg
// Item types, codes and controller states shared by the unit allocator.
// ----------------------------------------------------------------------------
package tuea_pkg;

    typedef struct packed {
        logic        operation;
        logic        direction;
        logic [10:0] unit_count;
        logic [9:0]  region_index;
    } req_item_t;

    typedef struct packed {
        logic        ok;
        logic [9:0]  block_start;
        logic [10:0] free_total;
    } rsp_item_t;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;
    localparam logic DIR_LOW    = 1'b0;
    localparam logic DIR_HIGH   = 1'b1;

    // Register index decoded from paddr[2]
    localparam logic REG_UNITS_IN_USE = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_WALK,
        ST_GAP,
        ST_REL,
        ST_REL_WALK,
        ST_PREV,
        ST_NEXT_RD,
        ST_NEXT,
        ST_REL_FIN,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// File: rtl/tuea_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tuea_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tuea_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/tuea_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tuea_ctrl
// Sequencer that walks boundary tags, splits and merges blocks, tracks the
// zone pointers and free counts, and holds the result register.
// ----------------------------------------------------------------------------
module tuea_ctrl
    import tuea_pkg::*;
#(
    parameter int MAX_UNITS = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire req_item_t                         req,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_stall,
    output rsp_item_t                              rsp,
    input  wire logic [$clog2(MAX_UNITS+1)-1:0]    units,
    input  wire logic                              cfg_clr,
    input  wire logic [$clog2(MAX_UNITS+1)-1:0]    cfg_units,
    output logic                                   tag_we,
    output logic      [$clog2(MAX_UNITS)-1:0]      tag_waddr,
    output logic      [$clog2(MAX_UNITS+1):0]      tag_wdata,
    output logic                                   tag_re,
    output logic      [$clog2(MAX_UNITS)-1:0]      tag_raddr,
    input  wire logic [$clog2(MAX_UNITS+1):0]      tag_rdata
);

    localparam int IW = $clog2(MAX_UNITS);
    localparam int CW = $clog2(MAX_UNITS + 1);
    localparam int AW = (CW > 11) ? CW : 11;
    localparam logic [CW-1:0] UNITS_RST = CW'((MAX_UNITS < 1024) ? MAX_UNITS : 1024);

    state_t state_reg, state_next;

    logic          op_reg, op_next;
    logic          dir_reg, dir_next;
    logic [AW-1:0] n_reg, n_next;
    logic [AW-1:0] r_reg, r_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] size_reg, size_next;
    logic [CW-1:0] end_reg, end_next;
    logic          ok_reg, ok_next;
    logic [CW-1:0] start_reg, start_next;
    logic [CW-1:0] low_end_reg, low_end_next;
    logic [CW-1:0] high_start_reg, high_start_next;
    logic [CW-1:0] low_free_reg, low_free_next;
    logic [CW-1:0] high_free_reg, high_free_next;
    logic [CW-1:0] free_reg, free_next;

    logic [CW-1:0] blk_start_reg [2];
    logic [CW-1:0] blk_start_next [2];
    logic [CW-1:0] blk_len_reg [2];
    logic [CW-1:0] blk_len_next [2];
    logic          blk_free_reg [2];
    logic          blk_free_next [2];
    logic          two_reg, two_next;
    logic [1:0]    wi_reg, wi_next;

    logic          out_valid_reg, out_valid_next;
    rsp_item_t     out_reg, out_next;

    logic          t_free;
    logic [CW-1:0] t_len;
    logic [CW-1:0] n_c;
    logic [CW-1:0] r_c;
    logic          alloc_bad;
    logic [CW-1:0] zone_free;
    logic          walk_in;
    logic [CW-1:0] walk_lim;
    logic          walk_bad;
    logic          walk_fit;
    logic [CW-1:0] walk_cur;
    logic [CW-1:0] walk_addr;
    logic          gap_ok;
    logic          in_left;
    logic          in_right;
    logic          rw_bad;
    logic          head_bad;
    logic [CW-1:0] rw_cur;
    logic          prev_ok;
    logic          next_ok;
    logic          need_next;
    logic          wsel;
    logic          last_write;
    logic          rel_merge_zone;
    logic          out_free;
    logic [AW-1:0] start_ext;
    logic [AW-1:0] free_ext;
    logic [CW-1:0] wr_addr_c;

    assign t_free    = tag_rdata[CW];
    assign t_len     = tag_rdata[CW-1:0];
    assign n_c       = n_reg[CW-1:0];
    assign r_c       = r_reg[CW-1:0];
    assign alloc_bad = (n_reg == '0) || (n_reg > AW'(units));
    assign zone_free = dir_reg ? high_free_reg : low_free_reg;

    assign walk_in   = dir_reg ? (cur_reg > high_start_reg) : (cur_reg < low_end_reg);
    assign walk_lim  = dir_reg ? (cur_reg - high_start_reg) : (low_end_reg - cur_reg);
    assign walk_bad  = (t_len == '0) || (t_len > walk_lim);
    assign walk_fit  = t_free && (t_len >= n_c);
    assign walk_cur  = dir_reg ? (cur_reg - t_len) : (cur_reg + t_len);
    assign walk_addr = dir_reg ? (walk_cur - CW'(1)) : walk_cur;
    assign gap_ok    = (low_end_reg < high_start_reg)
                     && ((high_start_reg - low_end_reg) >= n_c);

    assign in_left   = r_reg < AW'(low_end_reg);
    assign in_right  = (r_reg >= AW'(high_start_reg)) && (r_reg < AW'(units));
    assign rw_bad    = (t_len == '0) || (t_len > (hi_reg - cur_reg));
    assign head_bad  = t_free || (t_len == '0) || (t_len > (hi_reg - r_c));
    assign rw_cur    = cur_reg + t_len;
    assign prev_ok   = t_free && (t_len != '0) && (t_len <= (r_c - lo_reg));
    assign next_ok   = t_free && (t_len != '0) && (t_len <= (hi_reg - end_reg));
    assign need_next = (end_reg != low_end_reg) && (end_reg != units);
    assign rel_merge_zone = (end_reg == low_end_reg) || (r_c == high_start_reg);

    assign wsel       = wi_reg[1];
    assign last_write = (wi_reg == {two_reg, 1'b1});
    assign wr_addr_c  = wi_reg[0] ? (blk_start_reg[wsel] + blk_len_reg[wsel] - CW'(1))
                                  : blk_start_reg[wsel];
    assign out_free   = !out_valid_reg || !rsp_stall;
    assign start_ext  = AW'(start_reg);
    assign free_ext   = AW'(free_reg);

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req.operation == OP_RELEASE) ? ST_REL : ST_ALLOC;
                end
            end
            ST_ALLOC:
            begin
                if (alloc_bad)
                begin
                    state_next = ST_DONE;
                end
                else if (zone_free >= n_c)
                begin
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_GAP;
                end
            end
            ST_WALK:
            begin
                if (!walk_in || walk_bad)
                begin
                    state_next = ST_GAP;
                end
                else if (walk_fit)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_GAP:
            begin
                state_next = gap_ok ? ST_WRITE : ST_DONE;
            end
            ST_REL:
            begin
                state_next = (in_left || in_right) ? ST_REL_WALK : ST_DONE;
            end
            ST_REL_WALK:
            begin
                if (cur_reg > r_c)
                begin
                    state_next = ST_DONE;
                end
                else if (cur_reg < r_c)
                begin
                    if (rw_bad)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (head_bad)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = (r_c != lo_reg) ? ST_PREV : ST_NEXT_RD;
                end
            end
            ST_PREV:
            begin
                state_next = ST_NEXT_RD;
            end
            ST_NEXT_RD:
            begin
                state_next = need_next ? ST_NEXT : ST_REL_FIN;
            end
            ST_NEXT:
            begin
                state_next = ST_REL_FIN;
            end
            ST_REL_FIN:
            begin
                state_next = rel_merge_zone ? ST_DONE : ST_WRITE;
            end
            ST_WRITE:
            begin
                if (last_write)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        op_next          = op_reg;
        dir_next         = dir_reg;
        n_next           = n_reg;
        r_next           = r_reg;
        cur_next         = cur_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        idx_next         = idx_reg;
        size_next        = size_reg;
        end_next         = end_reg;
        ok_next          = ok_reg;
        start_next       = start_reg;
        low_end_next     = low_end_reg;
        high_start_next  = high_start_reg;
        low_free_next    = low_free_reg;
        high_free_next   = high_free_reg;
        free_next        = free_reg;
        blk_start_next   = blk_start_reg;
        blk_len_next     = blk_len_reg;
        blk_free_next    = blk_free_reg;
        two_next         = two_reg;
        wi_next          = wi_reg;
        out_valid_next   = out_valid_reg && rsp_stall;
        out_next         = out_reg;
        tag_we           = 1'b0;
        tag_waddr        = wr_addr_c[IW-1:0];
        tag_wdata        = {blk_free_reg[wsel], blk_len_reg[wsel]};
        tag_re           = 1'b0;
        tag_raddr        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.operation;
                    dir_next   = req.direction;
                    n_next     = AW'(req.unit_count);
                    r_next     = AW'(req.region_index);
                    ok_next    = 1'b0;
                    start_next = '0;
                    wi_next    = '0;
                    two_next   = 1'b0;
                end
            end
            ST_ALLOC:
            begin
                cur_next  = dir_reg ? units : '0;
                tag_re    = 1'b1;
                tag_raddr = dir_reg ? IW'(units - CW'(1)) : '0;
            end
            ST_WALK:
            begin
                if (walk_in && !walk_bad)
                begin
                    if (walk_fit)
                    begin
                        ok_next     = 1'b1;
                        free_next   = free_reg - n_c;
                        two_next    = t_len > n_c;
                        blk_len_next[0]  = n_c;
                        blk_free_next[0] = 1'b0;
                        blk_len_next[1]  = t_len - n_c;
                        blk_free_next[1] = 1'b1;
                        if (dir_reg == DIR_HIGH)
                        begin
                            high_free_next    = high_free_reg - n_c;
                            blk_start_next[0] = cur_reg - n_c;
                            blk_start_next[1] = walk_cur;
                            start_next        = cur_reg - n_c;
                        end
                        else
                        begin
                            low_free_next     = low_free_reg - n_c;
                            blk_start_next[0] = cur_reg;
                            blk_start_next[1] = cur_reg + n_c;
                            start_next        = cur_reg;
                        end
                    end
                    else
                    begin
                        // Advance to the next block and fetch its tag
                        cur_next  = walk_cur;
                        tag_re    = 1'b1;
                        tag_raddr = walk_addr[IW-1:0];
                    end
                end
            end
            ST_GAP:
            begin
                if (gap_ok)
                begin
                    ok_next          = 1'b1;
                    free_next        = free_reg - n_c;
                    two_next         = 1'b0;
                    blk_len_next[0]  = n_c;
                    blk_free_next[0] = 1'b0;
                    if (dir_reg == DIR_HIGH)
                    begin
                        high_start_next   = high_start_reg - n_c;
                        blk_start_next[0] = high_start_reg - n_c;
                        start_next        = high_start_reg - n_c;
                    end
                    else
                    begin
                        low_end_next      = low_end_reg + n_c;
                        blk_start_next[0] = low_end_reg;
                        start_next        = low_end_reg;
                    end
                end
            end
            ST_REL:
            begin
                dir_next  = !in_left;
                lo_next   = in_left ? '0 : high_start_reg;
                hi_next   = in_left ? low_end_reg : units;
                cur_next  = in_left ? '0 : high_start_reg;
                tag_re    = 1'b1;
                tag_raddr = in_left ? '0 : high_start_reg[IW-1:0];
            end
            ST_REL_WALK:
            begin
                if (cur_reg < r_c)
                begin
                    cur_next  = rw_cur;
                    tag_re    = 1'b1;
                    tag_raddr = rw_cur[IW-1:0];
                end
                else if ((cur_reg == r_c) && !head_bad)
                begin
                    ok_next   = 1'b1;
                    idx_next  = r_c;
                    size_next = t_len;
                    end_next  = r_c + t_len;
                    free_next = free_reg + t_len;
                    if (dir_reg == DIR_HIGH)
                    begin
                        high_free_next = high_free_reg + t_len;
                    end
                    else
                    begin
                        low_free_next = low_free_reg + t_len;
                    end
                    tag_re    = 1'b1;
                    tag_raddr = IW'(r_c - CW'(1));
                end
            end
            ST_PREV:
            begin
                if (prev_ok)
                begin
                    idx_next  = idx_reg - t_len;
                    size_next = size_reg + t_len;
                end
            end
            ST_NEXT_RD:
            begin
                tag_re    = 1'b1;
                tag_raddr = end_reg[IW-1:0];
            end
            ST_NEXT:
            begin
                if (next_ok)
                begin
                    size_next = size_reg + t_len;
                    end_next  = end_reg + t_len;
                end
            end
            ST_REL_FIN:
            begin
                if (end_reg == low_end_reg)
                begin
                    low_free_next = low_free_reg - size_reg;
                    low_end_next  = idx_reg;
                end
                else if (r_c == high_start_reg)
                begin
                    high_free_next  = high_free_reg - size_reg;
                    high_start_next = idx_reg + size_reg;
                end
                else
                begin
                    blk_start_next[0] = idx_reg;
                    blk_len_next[0]   = size_reg;
                    blk_free_next[0]  = 1'b1;
                    two_next          = 1'b0;
                end
            end
            ST_WRITE:
            begin
                tag_we  = 1'b1;
                wi_next = wi_reg + 2'd1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.ok          = ok_reg;
                    out_next.block_start = (op_reg == OP_RELEASE) ? r_reg[9:0]
                                                                  : start_ext[9:0];
                    out_next.free_total  = free_ext[10:0];
                end
            end
            default:
            begin
            end
        endcase

        // Register write empties the allocator
        if (cfg_clr)
        begin
            low_end_next    = '0;
            high_start_next = cfg_units;
            low_free_next   = '0;
            high_free_next  = '0;
            free_next       = cfg_units;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            low_end_reg    <= '0;
            high_start_reg <= UNITS_RST;
            low_free_reg   <= '0;
            high_free_reg  <= '0;
            free_reg       <= UNITS_RST;
            out_valid_reg  <= 1'b0;
            wi_reg         <= '0;
            two_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            low_end_reg    <= low_end_next;
            high_start_reg <= high_start_next;
            low_free_reg   <= low_free_next;
            high_free_reg  <= high_free_next;
            free_reg       <= free_next;
            out_valid_reg  <= out_valid_next;
            wi_reg         <= wi_next;
            two_reg        <= two_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        dir_reg       <= dir_next;
        n_reg         <= n_next;
        r_reg         <= r_next;
        cur_reg       <= cur_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        idx_reg       <= idx_next;
        size_reg      <= size_next;
        end_reg       <= end_next;
        ok_reg        <= ok_next;
        start_reg     <= start_next;
        blk_start_reg <= blk_start_next;
        blk_len_reg   <= blk_len_next;
        blk_free_reg  <= blk_free_next;
        out_reg       <= out_next;
    end

endmodule
`default_nettype wire

// File: rtl/two_ended_unit_region_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Allocate: walks the zone's blocks for a fit, else tries the gap between the zones,
//   then makes 2 or 4 tag writes.
// Release: an index outside both zones is rejected; else walks the blocks up to the
//   released one, reads the neighbor tags and makes 0 or 2 tag writes.
// One item at a time; a result held by the receiver stalls the next item in DONE.
// Reset empties both zones with units_in_use at min(MAX_UNITS, 1024); no clearing pass.
// ----------------------------------------------------------------------------
// two_ended_unit_region_allocator
// Two-ended first-fit unit allocator with boundary tags kept in one RAM.
// ----------------------------------------------------------------------------
module two_ended_unit_region_allocator
    import tuea_pkg::*;
#(
    parameter int MAX_UNITS = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire req_item_t   req,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output rsp_item_t        rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int IW = $clog2(MAX_UNITS);
    localparam int CW = $clog2(MAX_UNITS + 1);
    localparam int AW = (CW > 11) ? CW : 11;
    localparam logic [CW-1:0] UNITS_RST = CW'((MAX_UNITS < 1024) ? MAX_UNITS : 1024);

    logic [CW-1:0]   units_reg, units_next;
    logic            cfg_clr;
    logic [AW-1:0]   wr_raw;
    logic [AW-1:0]   wr_min;
    logic [AW-1:0]   wr_val;
    logic            tag_we;
    logic [IW-1:0]   tag_waddr;
    logic [CW:0]     tag_wdata;
    logic            tag_re;
    logic [IW-1:0]   tag_raddr;
    logic [CW:0]     tag_rdata;

    assign pready  = 1'b1;
    assign cfg_clr = psel && penable && pwrite && (paddr[2] == REG_UNITS_IN_USE);

    // Clamp the written count to 1 .. MAX_UNITS
    assign wr_raw = AW'(pwdata[10:0]);
    assign wr_min = (wr_raw == '0) ? AW'(1) : wr_raw;
    assign wr_val = (wr_min > AW'(MAX_UNITS)) ? AW'(MAX_UNITS) : wr_min;

    assign units_next = cfg_clr ? wr_val[CW-1:0] : units_reg;
    assign prdata     = (paddr[2] == REG_UNITS_IN_USE) ? 32'(units_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            units_reg <= UNITS_RST;
        end
        else
        begin
            units_reg <= units_next;
        end
    end

    tuea_ctrl #(
        .MAX_UNITS (MAX_UNITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .units     (units_reg),
        .cfg_clr   (cfg_clr),
        .cfg_units (wr_val[CW-1:0]),
        .tag_we    (tag_we),
        .tag_waddr (tag_waddr),
        .tag_wdata (tag_wdata),
        .tag_re    (tag_re),
        .tag_raddr (tag_raddr),
        .tag_rdata (tag_rdata)
    );

    tuea_ram #(
        .WIDTH (CW + 1),
        .DEPTH (MAX_UNITS)
    ) u_tags (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (tag_re),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

endmodule
`default_nettype wire
